// ===== rtl/efg_pkg.sv =====
// ----------------------------------------------------------------------------
// efg_pkg
// Shared types and codes for the event flag group unit.
// ----------------------------------------------------------------------------
`default_nettype none

package efg_pkg;

	localparam int FLAG_W = 32;
	localparam int TASK_W = 8;
	localparam int PRIO_W = 8;

	typedef enum logic [2:0] {
		CMD_SET    = 3'd0,
		CMD_CLEAR  = 3'd1,
		CMD_GET    = 3'd2,
		CMD_WAIT   = 3'd3,
		CMD_CANCEL = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_NO_WAIT  = 3'd1,
		ST_QUEUED   = 3'd2,
		ST_FULL     = 3'd3,
		ST_NOTFOUND = 3'd4,
		ST_EMPTY    = 3'd5
	} status_t;

	typedef enum logic [0:0] {
		KIND_REPLY  = 1'b0,
		KIND_NOTICE = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SET_SCAN,
		S_INS_SCAN,
		S_CAN_SCAN,
		S_OUT
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/event_flag_group_unit_top.sv =====
// ----------------------------------------------------------------------------
// event_flag_group_unit_top
// Event flag word with a priority-ordered table of blocked waiters.
// ----------------------------------------------------------------------------
// Commands arrive one beat at a time and the block is not ready until the
// last result beat of the previous command has been taken. A single scan
// cursor walks the waiter table one slot per cycle while scanning, sharing
// one condition / priority / task compare; a set pauses at each woken
// waiter until its notice beat is taken. Set: a scan of up to WAITER_SLOTS
// slots, a wake notice beat per woken waiter, then the reply beat. Wait
// that enqueues: a scan of up to WAITER_SLOTS slots, then the reply beat.
// Cancel: a scan to the task or table end, then the reply. Clear, get and
// immediate wait reply directly. Output beats stall on m_axis_tready.
`default_nettype none

module event_flag_group_unit_top #(
	parameter int WAITER_SLOTS = 8,
	parameter int MASK_BITS    = 24
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// bits[31:0], need_all, clr_on_wake, may_block, task_id[7:0],
	// task_priority[7:0], zero pad
	input  wire logic [55:0] s_axis_tdata,
	// command[2:0]
	input  wire logic [2:0]  s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// task_id_res[7:0], value[31:0], status[2:0], yield_hint, zero pad
	output logic [47:0]      m_axis_tdata,
	// kind
	output logic             m_axis_tuser,
	// last
	output logic             m_axis_tlast
);

	localparam int CNT_W = $clog2(WAITER_SLOTS + 1);
	localparam int IDX_W = (WAITER_SLOTS > 1) ? $clog2(WAITER_SLOTS) : 1;
	localparam int FW    = efg_pkg::FLAG_W;
	localparam int TW    = efg_pkg::TASK_W;
	localparam int PW    = efg_pkg::PRIO_W;

	efg_pkg::state_t state_q, state_d;

	// input unpack
	logic [FW-1:0]        in_bits;
	logic                 in_all, in_clr, in_block;
	logic [TW-1:0]        in_task;
	logic [PW-1:0]        in_prio;
	logic [MASK_BITS-1:0] in_mask;
	logic [FW-1:0]        in_mask32;
	logic                 in_cond;
	logic                 accept;

	assign in_bits   = s_axis_tdata[31:0];
	assign in_all    = s_axis_tdata[32];
	assign in_clr    = s_axis_tdata[33];
	assign in_block  = s_axis_tdata[34];
	assign in_task   = s_axis_tdata[42:35];
	assign in_prio   = s_axis_tdata[50:43];
	assign in_mask   = in_bits[MASK_BITS-1:0];
	assign in_mask32 = FW'(in_mask);

	// waiter table
	logic                 w_valid_q [WAITER_SLOTS];
	logic [MASK_BITS-1:0] w_mask_q  [WAITER_SLOTS];
	logic                 w_all_q   [WAITER_SLOTS];
	logic                 w_clr_q   [WAITER_SLOTS];
	logic [TW-1:0]        w_task_q  [WAITER_SLOTS];
	logic [PW-1:0]        w_prio_q  [WAITER_SLOTS];

	logic [FW-1:0]        flags_q;
	logic [CNT_W-1:0]     cursor_q;
	logic                 any_yield_q;

	logic [MASK_BITS-1:0] cmd_mask_q;
	logic                 cmd_all_q, cmd_clr_q;
	logic [TW-1:0]        cmd_task_q;
	logic [PW-1:0]        cmd_prio_q;

	logic                 res_kind_q;
	logic [TW-1:0]        res_task_q;
	logic [FW-1:0]        res_value_q;
	logic [2:0]           res_status_q;
	logic                 res_yield_q;
	logic                 res_last_q;

	// shared scan unit
	logic [IDX_W-1:0]     idx;
	logic                 at_end;
	logic [FW-1:0]        e_mask32;
	logic                 e_cond;
	logic [FW-1:0]        wake_flags;
	logic                 e_yield;
	logic                 rm_en, ins_en;
	logic                 full;

	assign idx      = cursor_q[IDX_W-1:0];
	assign at_end   = (cursor_q == CNT_W'(WAITER_SLOTS)) || !w_valid_q[idx];
	assign e_mask32 = FW'(w_mask_q[idx]);
	assign e_cond   = w_all_q[idx] ? ((flags_q & e_mask32) == e_mask32)
	                               : ((flags_q & e_mask32) != '0);
	assign wake_flags = w_clr_q[idx] ? (flags_q & ~e_mask32) : flags_q;
	assign e_yield  = w_prio_q[idx] < cmd_prio_q;
	assign full     = w_valid_q[WAITER_SLOTS-1];
	assign in_cond  = in_all ? ((flags_q & in_mask32) == in_mask32)
	                         : ((flags_q & in_mask32) != '0);

	assign s_axis_tready = (state_q == efg_pkg::S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign m_axis_tvalid = (state_q == efg_pkg::S_OUT);
	assign m_axis_tdata  = {4'b0, res_yield_q, res_status_q, res_value_q, res_task_q};
	assign m_axis_tuser  = res_kind_q;
	assign m_axis_tlast  = res_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= efg_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		rm_en   = 1'b0;
		ins_en  = 1'b0;
		unique case (state_q)
			efg_pkg::S_IDLE: begin
				if (accept) begin
					if (s_axis_tuser == efg_pkg::CMD_SET) begin
						state_d = efg_pkg::S_SET_SCAN;
					end else if (s_axis_tuser == efg_pkg::CMD_CANCEL) begin
						state_d = efg_pkg::S_CAN_SCAN;
					end else if (s_axis_tuser == efg_pkg::CMD_WAIT && in_mask != '0
					             && !in_cond && in_block && !full) begin
						state_d = efg_pkg::S_INS_SCAN;
					end else begin
						state_d = efg_pkg::S_OUT;
					end
				end
			end
			efg_pkg::S_SET_SCAN: begin
				if (at_end) begin
					state_d = efg_pkg::S_OUT;
				end else if (e_cond) begin
					rm_en   = 1'b1;
					state_d = efg_pkg::S_OUT;
				end
			end
			efg_pkg::S_CAN_SCAN: begin
				if (at_end) begin
					state_d = efg_pkg::S_OUT;
				end else if (w_task_q[idx] == cmd_task_q) begin
					rm_en   = 1'b1;
					state_d = efg_pkg::S_OUT;
				end
			end
			efg_pkg::S_INS_SCAN: begin
				if (at_end || w_prio_q[idx] > cmd_prio_q) begin
					ins_en  = 1'b1;
					state_d = efg_pkg::S_OUT;
				end
			end
			efg_pkg::S_OUT: begin
				if (m_axis_tready) begin
					state_d = res_last_q ? efg_pkg::S_IDLE : efg_pkg::S_SET_SCAN;
				end
			end
			default: state_d = efg_pkg::S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q     <= '0;
			cursor_q    <= '0;
			any_yield_q <= 1'b0;
		end else begin
			case (state_q)
				efg_pkg::S_IDLE: begin
					cursor_q    <= '0;
					any_yield_q <= 1'b0;
					if (accept) begin
						case (s_axis_tuser)
							efg_pkg::CMD_SET:   flags_q <= flags_q | in_bits;
							efg_pkg::CMD_CLEAR: flags_q <= flags_q & ~in_bits;
							efg_pkg::CMD_WAIT: begin
								if (in_mask != '0 && in_cond && in_clr) begin
									flags_q <= flags_q & ~in_mask32;
								end
							end
							default: ;
						endcase
					end
				end
				efg_pkg::S_SET_SCAN: begin
					if (!at_end) begin
						if (e_cond) begin
							flags_q     <= wake_flags;
							any_yield_q <= any_yield_q | e_yield;
						end else begin
							cursor_q <= cursor_q + CNT_W'(1);
						end
					end
				end
				efg_pkg::S_CAN_SCAN, efg_pkg::S_INS_SCAN: begin
					if (state_d != efg_pkg::S_OUT) begin
						cursor_q <= cursor_q + CNT_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// command latch and result register
	always_ff @(posedge clk) begin
		case (state_q)
			efg_pkg::S_IDLE: begin
				if (accept) begin
					cmd_mask_q   <= in_mask;
					cmd_all_q    <= in_all;
					cmd_clr_q    <= in_clr;
					cmd_task_q   <= in_task;
					cmd_prio_q   <= in_prio;
					res_kind_q   <= efg_pkg::KIND_REPLY;
					res_task_q   <= in_task;
					res_yield_q  <= 1'b0;
					res_last_q   <= 1'b1;
					res_value_q  <= flags_q;
					res_status_q <= efg_pkg::ST_OK;
					if (s_axis_tuser == efg_pkg::CMD_WAIT) begin
						if (in_mask == '0) begin
							res_value_q  <= '0;
							res_status_q <= efg_pkg::ST_EMPTY;
						end else if (!in_cond) begin
							res_value_q <= '0;
							if (!in_block) begin
								res_status_q <= efg_pkg::ST_NO_WAIT;
							end else if (full) begin
								res_status_q <= efg_pkg::ST_FULL;
							end
						end
					end
				end
			end
			efg_pkg::S_SET_SCAN: begin
				if (at_end) begin
					res_kind_q   <= efg_pkg::KIND_REPLY;
					res_task_q   <= cmd_task_q;
					res_value_q  <= flags_q;
					res_status_q <= efg_pkg::ST_OK;
					res_yield_q  <= any_yield_q;
					res_last_q   <= 1'b1;
				end else if (e_cond) begin
					res_kind_q   <= efg_pkg::KIND_NOTICE;
					res_task_q   <= w_task_q[idx];
					res_value_q  <= wake_flags;
					res_status_q <= efg_pkg::ST_OK;
					res_yield_q  <= e_yield;
					res_last_q   <= 1'b0;
				end
			end
			efg_pkg::S_CAN_SCAN: begin
				res_value_q  <= '0;
				res_status_q <= at_end ? efg_pkg::ST_NOTFOUND : efg_pkg::ST_OK;
			end
			efg_pkg::S_INS_SCAN: begin
				res_value_q  <= '0;
				res_status_q <= efg_pkg::ST_QUEUED;
			end
			default: ;
		endcase
	end

	// waiter table shifting: remove at cursor or insert at cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < WAITER_SLOTS; j++) begin
				w_valid_q[j] <= 1'b0;
			end
		end else begin
			for (int j = 0; j < WAITER_SLOTS; j++) begin
				if (ins_en) begin
					if (j == int'(idx)) begin
						w_valid_q[j] <= 1'b1;
					end else if (j > int'(idx)) begin
						w_valid_q[j] <= w_valid_q[(j > 0) ? j - 1 : 0];
					end
				end else if (rm_en && j >= int'(idx)) begin
					w_valid_q[j] <= (j < WAITER_SLOTS - 1) ?
						w_valid_q[(j < WAITER_SLOTS - 1) ? j + 1 : j] : 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < WAITER_SLOTS; j++) begin
			if (ins_en) begin
				if (j == int'(idx)) begin
					w_mask_q[j] <= cmd_mask_q;
					w_all_q[j]  <= cmd_all_q;
					w_clr_q[j]  <= cmd_clr_q;
					w_task_q[j] <= cmd_task_q;
					w_prio_q[j] <= cmd_prio_q;
				end else if (j > int'(idx)) begin
					w_mask_q[j] <= w_mask_q[(j > 0) ? j - 1 : 0];
					w_all_q[j]  <= w_all_q[(j > 0) ? j - 1 : 0];
					w_clr_q[j]  <= w_clr_q[(j > 0) ? j - 1 : 0];
					w_task_q[j] <= w_task_q[(j > 0) ? j - 1 : 0];
					w_prio_q[j] <= w_prio_q[(j > 0) ? j - 1 : 0];
				end
			end else if (rm_en && j >= int'(idx) && j < WAITER_SLOTS - 1) begin
				w_mask_q[j] <= w_mask_q[(j < WAITER_SLOTS - 1) ? j + 1 : j];
				w_all_q[j]  <= w_all_q[(j < WAITER_SLOTS - 1) ? j + 1 : j];
				w_clr_q[j]  <= w_clr_q[(j < WAITER_SLOTS - 1) ? j + 1 : j];
				w_task_q[j] <= w_task_q[(j < WAITER_SLOTS - 1) ? j + 1 : j];
				w_prio_q[j] <= w_prio_q[(j < WAITER_SLOTS - 1) ? j + 1 : j];
			end
		end
	end

endmodule

`default_nettype wire

// ===== dv/efg_tb_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// efg_tb_pkg
// Command and result beat types plus a shadow of the flag word and waiter
// table. The shadow predicts the result beats owed for each accepted command
// and compares every returned beat against the oldest one still owed.
// ----------------------------------------------------------------------------

package efg_tb_pkg;

	localparam int WAITERS = 8;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [31:0] bits;
		logic        need_all;
		logic        clr_on_wake;
		logic        may_block;
		logic [7:0]  task_id;
		logic [7:0]  task_prio;
	} flag_cmd_t;

	typedef struct {
		logic        kind;
		logic [7:0]  task_id;
		logic [31:0] value;
		logic [2:0]  status;
		logic        yield_hint;
		logic        last;
	} flag_beat_t;

	class flag_group_shadow;
		logic [31:0] flags;
		int          depth;
		logic [23:0] w_mask[WAITERS];
		logic        w_all[WAITERS];
		logic        w_clr[WAITERS];
		logic [7:0]  w_task[WAITERS];
		logic [7:0]  w_prio[WAITERS];
		flag_beat_t  owed_beats[$];
		int          mismatches;

		function new();
			flags      = '0;
			depth      = 0;
			mismatches = 0;
		endfunction

		function int owed();
			return owed_beats.size();
		endfunction

		function bit holds(logic [31:0] f, logic [23:0] m, logic all_bits);
			logic [31:0] wide;
			wide = {8'h00, m};
			if (all_bits)
				return (f & wide) == wide;
			return (f & wide) != '0;
		endfunction

		function void owe(logic kind, logic [7:0] tid, logic [31:0] value,
				logic [2:0] status, logic yield_hint, logic last);
			flag_beat_t b;
			b.kind       = kind;
			b.task_id    = tid;
			b.value      = value;
			b.status     = status;
			b.yield_hint = yield_hint;
			b.last       = last;
			owed_beats.push_back(b);
		endfunction

		function void drop_waiter(int idx);
			for (int i = idx; i < depth - 1; i++) begin
				w_mask[i] = w_mask[i + 1];
				w_all[i]  = w_all[i + 1];
				w_clr[i]  = w_clr[i + 1];
				w_task[i] = w_task[i + 1];
				w_prio[i] = w_prio[i + 1];
			end
			depth--;
		endfunction

		function void apply_command(flag_cmd_t c);
			logic [23:0] m;
			logic [31:0] prior;
			logic        hint;
			logic        y;
			int          i;
			int          pos;
			m = c.bits[23:0];
			case (c.cmd)
				efg_pkg::CMD_SET: begin
					hint  = 1'b0;
					flags = flags | c.bits;
					i     = 0;
					while (i < depth) begin
						if (holds(flags, w_mask[i], w_all[i])) begin
							y = (w_prio[i] < c.task_prio);
							if (w_clr[i])
								flags = flags & ~{8'h00, w_mask[i]};
							owe(efg_pkg::KIND_NOTICE, w_task[i], flags, efg_pkg::ST_OK,
								y, 1'b0);
							hint = hint | y;
							drop_waiter(i);
						end else begin
							i++;
						end
					end
					owe(efg_pkg::KIND_REPLY, c.task_id, flags, efg_pkg::ST_OK, hint, 1'b1);
				end
				efg_pkg::CMD_CLEAR: begin
					prior = flags;
					flags = flags & ~c.bits;
					owe(efg_pkg::KIND_REPLY, c.task_id, prior, efg_pkg::ST_OK, 1'b0, 1'b1);
				end
				efg_pkg::CMD_WAIT: begin
					if (m == '0) begin
						owe(efg_pkg::KIND_REPLY, c.task_id, '0, efg_pkg::ST_EMPTY, 1'b0, 1'b1);
					end else if (holds(flags, m, c.need_all)) begin
						prior = flags;
						if (c.clr_on_wake)
							flags = flags & ~{8'h00, m};
						owe(efg_pkg::KIND_REPLY, c.task_id, prior, efg_pkg::ST_OK, 1'b0, 1'b1);
					end else if (!c.may_block) begin
						owe(efg_pkg::KIND_REPLY, c.task_id, '0, efg_pkg::ST_NO_WAIT,
							1'b0, 1'b1);
					end else if (depth >= WAITERS) begin
						owe(efg_pkg::KIND_REPLY, c.task_id, '0, efg_pkg::ST_FULL, 1'b0, 1'b1);
					end else begin
						pos = 0;
						while (pos < depth && w_prio[pos] <= c.task_prio)
							pos++;
						for (i = depth; i > pos; i--) begin
							w_mask[i] = w_mask[i - 1];
							w_all[i]  = w_all[i - 1];
							w_clr[i]  = w_clr[i - 1];
							w_task[i] = w_task[i - 1];
							w_prio[i] = w_prio[i - 1];
						end
						w_mask[pos] = m;
						w_all[pos]  = c.need_all;
						w_clr[pos]  = c.clr_on_wake;
						w_task[pos] = c.task_id;
						w_prio[pos] = c.task_prio;
						depth++;
						owe(efg_pkg::KIND_REPLY, c.task_id, '0, efg_pkg::ST_QUEUED,
							1'b0, 1'b1);
					end
				end
				efg_pkg::CMD_CANCEL: begin
					pos = -1;
					for (i = depth - 1; i >= 0; i--)
						if (w_task[i] == c.task_id)
							pos = i;
					if (pos >= 0) begin
						drop_waiter(pos);
						owe(efg_pkg::KIND_REPLY, c.task_id, '0, efg_pkg::ST_OK, 1'b0, 1'b1);
					end else begin
						owe(efg_pkg::KIND_REPLY, c.task_id, '0, efg_pkg::ST_NOTFOUND,
							1'b0, 1'b1);
					end
				end
				default: begin
					owe(efg_pkg::KIND_REPLY, c.task_id, flags, efg_pkg::ST_OK, 1'b0, 1'b1);
				end
			endcase
		endfunction

		function void check_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
				mismatches++;
			end
		endfunction

		function void match_beat(flag_beat_t got);
			flag_beat_t want;
			if (owed_beats.size() == 0) begin
				$error("result beat with none owed: task 0x%0h value 0x%0h",
					got.task_id, got.value);
				mismatches++;
			end else begin
				want = owed_beats.pop_front();
				check_field("kind", want.kind, got.kind);
				check_field("task_id_res", want.task_id, got.task_id);
				check_field("value", want.value, got.value);
				check_field("status", want.status, got.status);
				check_field("yield_hint", want.yield_hint, got.yield_hint);
				check_field("last", want.last, got.last);
			end
		endfunction
	endclass

endpackage

// ===== dv/tb_event_flag_group_unit_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_event_flag_group_unit_top
// Drives directed and random flag commands into the event flag group unit
// with bursty input and a stalling output, and compares every result beat
// with the beats predicted by a shadow of the flag word and waiter table.
// ----------------------------------------------------------------------------

module tb_event_flag_group_unit_top;

	localparam int CYCLE_LIMIT = 200000;

	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        s_axis_tvalid  = 1'b0;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata   = '0;
	logic [2:0]  s_axis_tuser   = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready  = 1'b0;
	logic [47:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;

	efg_tb_pkg::flag_group_shadow shadow = new();

	int       cycles     = 0;
	int       burst_left = 1;
	int       gap_max    = 6;
	logic [7:0] stall_bits = 8'hFF;
	logic [2:0] stall_idx  = '0;

	event_flag_group_unit_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("event_flag_group_unit_top verification failed");
			$finish;
		end
	end

	// output stall pattern, reshuffled each time the pattern index wraps
	always @(negedge clk) begin
		m_axis_tready <= stall_bits[stall_idx];
		stall_idx     <= stall_idx + 3'd1;
		if (stall_idx == 3'd7) begin
			if ($urandom_range(0, 3) == 0)
				stall_bits <= 8'hFF;
			else
				stall_bits <= 8'($urandom()) | 8'h01;
		end
	end

	always @(posedge clk) begin
		efg_tb_pkg::flag_beat_t b;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			b.kind       = m_axis_tuser;
			b.task_id    = m_axis_tdata[7:0];
			b.value      = m_axis_tdata[39:8];
			b.status     = m_axis_tdata[42:40];
			b.yield_hint = m_axis_tdata[43];
			b.last       = m_axis_tlast;
			shadow.match_beat(b);
		end
	end

	function automatic efg_tb_pkg::flag_cmd_t mk(logic [2:0] cmd, logic [31:0] bits,
			logic all_bits, logic clr, logic blk, logic [7:0] tid, logic [7:0] prio);
		efg_tb_pkg::flag_cmd_t c;
		c.cmd         = cmd;
		c.bits        = bits;
		c.need_all    = all_bits;
		c.clr_on_wake = clr;
		c.may_block   = blk;
		c.task_id     = tid;
		c.task_prio   = prio;
		return c;
	endfunction

	// a few bits, mostly in the low byte so that masks overlap
	function automatic logic [31:0] sparse_bits();
		logic [31:0] v;
		int          n;
		v = '0;
		n = $urandom_range(1, 3);
		repeat (n) begin
			if ($urandom_range(0, 3) == 0)
				v[$urandom_range(0, 23)] = 1'b1;
			else
				v[$urandom_range(0, 7)] = 1'b1;
		end
		return v;
	endfunction

	function automatic efg_tb_pkg::flag_cmd_t random_command();
		efg_tb_pkg::flag_cmd_t c;
		int                    pick;
		pick          = $urandom_range(0, 99);
		c.cmd         = efg_pkg::CMD_GET;
		c.bits        = sparse_bits();
		c.need_all    = 1'($urandom_range(0, 1));
		c.clr_on_wake = 1'($urandom_range(0, 1));
		c.may_block   = ($urandom_range(0, 5) != 0);
		c.task_id     = 8'($urandom_range(0, 15));
		c.task_prio   = 8'($urandom_range(0, 15));
		if ($urandom_range(0, 9) == 0) begin
			c.task_id   = 8'($urandom_range(0, 255));
			c.task_prio = 8'($urandom_range(0, 255));
		end
		if (pick < 38) begin
			c.cmd = efg_pkg::CMD_WAIT;
			if ($urandom_range(0, 3) == 0)
				c.bits = c.bits | ($urandom() & 32'hFF00_0000);
		end else if (pick < 62) begin
			c.cmd = efg_pkg::CMD_SET;
		end else if (pick < 74) begin
			c.cmd  = efg_pkg::CMD_CLEAR;
			c.bits = $urandom();
		end else if (pick < 80) begin
			c.cmd = efg_pkg::CMD_GET;
		end else if (pick < 92) begin
			c.cmd = efg_pkg::CMD_CANCEL;
		end else if (pick < 96) begin
			c.cmd = 3'($urandom_range(5, 7));
		end else begin
			c.cmd  = 3'($urandom_range(0, 7));
			c.bits = $urandom();
		end
		return c;
	endfunction

	// entered and left at a falling edge
	task automatic send(input efg_tb_pkg::flag_cmd_t c);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {5'd0, c.task_prio, c.task_id, c.may_block,
			c.clr_on_wake, c.need_all, c.bits};
		s_axis_tuser  <= c.cmd;
		do @(posedge clk); while (!s_axis_tready);
		shadow.apply_command(c);
		@(negedge clk);
		if (burst_left > 1) begin
			burst_left--;
		end else begin
			gap = $urandom_range(0, gap_max);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 8);
		end
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (shadow.owed() != 0)
			@(negedge clk);
	endtask

	initial begin
		int k;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send(mk(efg_pkg::CMD_GET,    32'h0000_0000, 1'b0, 1'b0, 1'b0, 8'd0,   8'd0));
		send(mk(efg_pkg::CMD_CLEAR,  32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 8'd255, 8'd255));
		send(mk(efg_pkg::CMD_WAIT,   32'hFF00_0000, 1'b1, 1'b1, 1'b1, 8'd1,   8'd3));
		send(mk(efg_pkg::CMD_WAIT,   32'h0000_0001, 1'b0, 1'b0, 1'b0, 8'd2,   8'd3));
		send(mk(efg_pkg::CMD_WAIT,   32'h0000_0001, 1'b0, 1'b1, 1'b1, 8'd7,   8'd20));
		send(mk(efg_pkg::CMD_WAIT,   32'h0000_0003, 1'b1, 1'b0, 1'b1, 8'd8,   8'd255));
		send(mk(efg_pkg::CMD_WAIT,   32'h0080_0000, 1'b0, 1'b0, 1'b1, 8'd7,   8'd20));
		send(mk(efg_pkg::CMD_WAIT,   32'h00FF_FFFF, 1'b1, 1'b1, 1'b1, 8'd255, 8'd0));
		send(mk(efg_pkg::CMD_WAIT,   32'h0000_0010, 1'b0, 1'b0, 1'b1, 8'd9,   8'd5));
		send(mk(efg_pkg::CMD_WAIT,   32'h0000_0020, 1'b0, 1'b1, 1'b1, 8'd10,  8'd20));
		send(mk(efg_pkg::CMD_WAIT,   32'h0000_0040, 1'b1, 1'b0, 1'b1, 8'd11,  8'd100));
		send(mk(efg_pkg::CMD_WAIT,   32'h0000_0080, 1'b0, 1'b0, 1'b1, 8'd0,   8'd100));
		send(mk(efg_pkg::CMD_WAIT,   32'h0000_0100, 1'b0, 1'b0, 1'b1, 8'd12,  8'd1));
		send(mk(efg_pkg::CMD_CANCEL, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 8'd7,   8'd20));
		send(mk(efg_pkg::CMD_CANCEL, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 8'd200, 8'd20));
		send(mk(efg_pkg::CMD_SET,    32'h0000_00F0, 1'b0, 1'b0, 1'b0, 8'd40,  8'd50));
		send(mk(efg_pkg::CMD_SET,    32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 8'd41,  8'd0));
		send(mk(3'd5,                32'h0000_0000, 1'b0, 1'b0, 1'b0, 8'd33,  8'd0));
		send(mk(3'd6,                32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 8'd34,  8'd255));
		send(mk(3'd7,                32'h1234_5678, 1'b0, 1'b1, 1'b0, 8'd35,  8'd7));
		send(mk(efg_pkg::CMD_SET,    32'h0000_0003, 1'b0, 1'b0, 1'b0, 8'd42,  8'd255));
		send(mk(efg_pkg::CMD_SET,    32'h00FF_FFFF, 1'b0, 1'b0, 1'b0, 8'd43,  8'd255));
		send(mk(efg_pkg::CMD_WAIT,   32'h00F0_F0F0, 1'b1, 1'b1, 1'b0, 8'd44,  8'd9));
		send(mk(efg_pkg::CMD_CANCEL, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 8'd0,   8'd0));
		send(mk(efg_pkg::CMD_CLEAR,  32'h0000_0000, 1'b0, 1'b0, 1'b0, 8'd45,  8'd9));
		drain();

		for (k = 0; k < 75; k++) begin
			if (k == 30)
				gap_max = 0;
			if (k == 46)
				gap_max = 6;
			if (k == 50)
				drain();
			send(random_command());
		end
		drain();
		repeat (30) @(posedge clk);

		if (shadow.mismatches == 0 && shadow.owed() == 0)
			$display("event_flag_group_unit_top verification clean");
		else
			$display("event_flag_group_unit_top verification failed");
		$finish;
	end

endmodule
